FILE: design/pip_pkg.sv
// Shared types and constants for the point-in-polygon zone test.
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 24;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [1:0] {
        ACT_BOX_RESET  = 2'd0,
        ACT_ADD_VERTEX = 2'd1,
        ACT_ADD_Z      = 2'd2,
        ACT_QUERY      = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_MIN_X = 3'd0,
        CFG_BOX_MAX_X = 3'd1,
        CFG_BOX_MIN_Y = 3'd2,
        CFG_BOX_MAX_Y = 3'd3,
        CFG_BOX_MIN_Z = 3'd4,
        CFG_BOX_MAX_Z = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QCHK,
        ST_QRD,
        ST_WRAP,
        ST_DRAIN,
        ST_DONE
    } pip_state_t;

    // controller -> datapath
    typedef struct packed {
        logic              accept;
        logic              qchk;
        logic              rd_en;
        logic [VIDX_W-1:0] rd_addr;
        logic              rd_first;
        logic              wrap;
        logic              res_q;
    } pip_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic              in_box;
        logic              poly;
        logic [VCNT_W-1:0] vcount;
        logic              busy;
    } pip_stat_t;

endpackage

FILE: design/pip_ctrl.sv
// Controller: handshake, output word valid, and query sequencing.
module pip_ctrl
    import pip_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    output logic        m_valid,
    input  logic        m_ready,
    input  pip_stat_t   stat,
    output pip_cmd_t    cmd
);

    pip_state_t        state_reg, state_next;
    logic [VIDX_W-1:0] cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;
    logic              accept;
    logic              last_rd;
    action_t           act;

    assign act      = action_t'(s_action);
    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign last_rd  = (VCNT_W'(cnt_reg) + VCNT_W'(1)) == stat.vcount;
    assign m_valid  = m_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept && act == ACT_QUERY) state_next = ST_QCHK;
            end
            ST_QCHK: begin
                if (stat.in_box && stat.poly) state_next = ST_QRD;
                else                          state_next = ST_DONE;
            end
            ST_QRD: begin
                cnt_next = cnt_reg + VIDX_W'(1);
                if (last_rd) state_next = ST_WRAP;
            end
            ST_WRAP:  state_next = ST_DRAIN;
            ST_DRAIN: begin
                if (!stat.busy) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        cmd.rd_addr  = cnt_reg;
        cmd.rd_first = (cnt_reg == '0);
        case (state_reg)
            ST_IDLE: begin
                s_ready    = out_free;
                cmd.accept = accept;
            end
            ST_QCHK:  cmd.qchk  = 1'b1;
            ST_QRD:   cmd.rd_en = 1'b1;
            ST_WRAP:  cmd.wrap  = 1'b1;
            ST_DRAIN: ;
            ST_DONE:  cmd.res_q = out_free;
            default:  ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if ((accept && act != ACT_QUERY) || cmd.res_q) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: design/pip_dpath.sv
// Datapath: config and bound registers, vertex memory, edge crossing pipeline.
module pip_dpath
    import pip_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_wdata,
    input  logic [1:0]                   s_action,
    input  logic signed [COORD_BITS-1:0] s_coord_x,
    input  logic signed [COORD_BITS-1:0] s_coord_y,
    input  logic signed [COORD_BITS-1:0] s_coord_z,
    input  logic signed [COORD_BITS-1:0] s_coord_z_second,
    input  pip_cmd_t                     cmd,
    output pip_stat_t                    stat,
    output logic                         m_inside_res,
    output logic                         m_table_full
);

    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;

    action_t act;
    assign act = action_t'(s_action);

    // configuration registers
    coord_t cfg_min_x_reg, cfg_max_x_reg, cfg_min_y_reg;
    coord_t cfg_max_y_reg, cfg_min_z_reg, cfg_max_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_min_x_reg <= '0;
            cfg_max_x_reg <= '0;
            cfg_min_y_reg <= '0;
            cfg_max_y_reg <= '0;
            cfg_min_z_reg <= '0;
            cfg_max_z_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_BOX_MIN_X: cfg_min_x_reg <= cfg_wdata;
                CFG_BOX_MAX_X: cfg_max_x_reg <= cfg_wdata;
                CFG_BOX_MIN_Y: cfg_min_y_reg <= cfg_wdata;
                CFG_BOX_MAX_Y: cfg_max_y_reg <= cfg_wdata;
                CFG_BOX_MIN_Z: cfg_min_z_reg <= cfg_wdata;
                CFG_BOX_MAX_Z: cfg_max_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // zone state
    coord_t            bmin_x_reg, bmax_x_reg, bmin_y_reg, bmax_y_reg;
    coord_t            bmin_z_reg, bmax_z_reg;
    logic              poly_reg;
    logic [VCNT_W-1:0] vcnt_reg;
    logic              full;
    logic              do_item;
    coord_t            zhi, zlo;

    assign full    = vcnt_reg >= VCNT_W'(MAX_VERTICES);
    assign do_item = cmd.accept;
    assign zhi     = (act == ACT_ADD_Z && s_coord_z_second > s_coord_z) ? s_coord_z_second
                                                                         : s_coord_z;
    assign zlo     = (act == ACT_ADD_Z && s_coord_z_second < s_coord_z) ? s_coord_z_second
                                                                         : s_coord_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bmin_x_reg <= CMAX;
            bmax_x_reg <= CMIN;
            bmin_y_reg <= CMAX;
            bmax_y_reg <= CMIN;
            bmin_z_reg <= CMAX;
            bmax_z_reg <= CMIN;
            poly_reg   <= 1'b0;
            vcnt_reg   <= '0;
        end else if (do_item) begin
            case (act)
                ACT_BOX_RESET: begin
                    bmin_x_reg <= cfg_min_x_reg;
                    bmax_x_reg <= cfg_max_x_reg;
                    bmin_y_reg <= cfg_min_y_reg;
                    bmax_y_reg <= cfg_max_y_reg;
                    bmin_z_reg <= cfg_min_z_reg;
                    bmax_z_reg <= cfg_max_z_reg;
                    poly_reg   <= 1'b0;
                    vcnt_reg   <= '0;
                end
                ACT_ADD_VERTEX: begin
                    if (!full) begin
                        vcnt_reg <= vcnt_reg + VCNT_W'(1);
                        poly_reg <= 1'b1;
                        if (s_coord_x > bmax_x_reg) bmax_x_reg <= s_coord_x;
                        if (s_coord_x < bmin_x_reg) bmin_x_reg <= s_coord_x;
                        if (s_coord_y > bmax_y_reg) bmax_y_reg <= s_coord_y;
                        if (s_coord_y < bmin_y_reg) bmin_y_reg <= s_coord_y;
                        if (zhi > bmax_z_reg) bmax_z_reg <= zhi;
                        if (zlo < bmin_z_reg) bmin_z_reg <= zlo;
                    end
                end
                ACT_ADD_Z: begin
                    if (zhi > bmax_z_reg) bmax_z_reg <= zhi;
                    if (zlo < bmin_z_reg) bmin_z_reg <= zlo;
                end
                default: ;
            endcase
        end
    end

    // vertex memory, one registered read port
    coord_t vx_mem [MAX_VERTICES];
    coord_t vy_mem [MAX_VERTICES];
    coord_t rd_x_reg, rd_y_reg;

    always_ff @(posedge aclk) begin
        if (do_item && act == ACT_ADD_VERTEX && !full) begin
            vx_mem[vcnt_reg[VIDX_W-1:0]] <= s_coord_x;
            vy_mem[vcnt_reg[VIDX_W-1:0]] <= s_coord_y;
        end
        if (cmd.rd_en) begin
            rd_x_reg <= vx_mem[cmd.rd_addr];
            rd_y_reg <= vy_mem[cmd.rd_addr];
        end
    end

    // query point
    coord_t px_reg, py_reg, pz_reg;

    always_ff @(posedge aclk) begin
        if (do_item && act == ACT_QUERY) begin
            px_reg <= s_coord_x;
            py_reg <= s_coord_y;
            pz_reg <= s_coord_z;
        end
    end

    assign stat.in_box = px_reg >= bmin_x_reg && px_reg <= bmax_x_reg &&
                         py_reg >= bmin_y_reg && py_reg <= bmax_y_reg &&
                         pz_reg >= bmin_z_reg && pz_reg <= bmax_z_reg;
    assign stat.poly   = poly_reg;
    assign stat.vcount = vcnt_reg;

    // edge pipeline valids
    logic rd_vld_reg, rd_first_reg, wrap_vld_reg;
    logic e_vld_reg, a_vld_reg, b_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            wrap_vld_reg <= 1'b0;
            e_vld_reg    <= 1'b0;
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
        end else begin
            rd_vld_reg   <= cmd.rd_en;
            rd_first_reg <= cmd.rd_first;
            wrap_vld_reg <= cmd.wrap;
            e_vld_reg    <= (rd_vld_reg && !rd_first_reg) || wrap_vld_reg;
            a_vld_reg    <= e_vld_reg;
            b_vld_reg    <= a_vld_reg;
        end
    end

    assign stat.busy = rd_vld_reg || wrap_vld_reg || e_vld_reg || a_vld_reg || b_vld_reg;

    // edge forming: consecutive vertices, then last back to first
    coord_t first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    coord_t ex1_reg, ey1_reg, ex2_reg, ey2_reg;

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
            if (rd_first_reg) begin
                first_x_reg <= rd_x_reg;
                first_y_reg <= rd_y_reg;
            end else begin
                ex1_reg <= prev_x_reg;
                ey1_reg <= prev_y_reg;
                ex2_reg <= rd_x_reg;
                ey2_reg <= rd_y_reg;
            end
        end else if (wrap_vld_reg) begin
            ex1_reg <= prev_x_reg;
            ey1_reg <= prev_y_reg;
            ex2_reg <= first_x_reg;
            ey2_reg <= first_y_reg;
        end
    end

    // stage A: classify edge, pick product operands
    diff_t dx1p, dx1n, dx2p, dx2n, dy1p, dy1n, dy2p, dy2n;
    diff_t ax, bx, nega, negb, uu, vv;
    logic  s1, s2, swap, xl1, horiz, outy, dec, dval;

    assign dx1p = {ex1_reg[COORD_BITS-1], ex1_reg} - {px_reg[COORD_BITS-1], px_reg};
    assign dx1n = {px_reg[COORD_BITS-1], px_reg} - {ex1_reg[COORD_BITS-1], ex1_reg};
    assign dx2p = {ex2_reg[COORD_BITS-1], ex2_reg} - {px_reg[COORD_BITS-1], px_reg};
    assign dx2n = {px_reg[COORD_BITS-1], px_reg} - {ex2_reg[COORD_BITS-1], ex2_reg};
    assign dy1p = {ey1_reg[COORD_BITS-1], ey1_reg} - {py_reg[COORD_BITS-1], py_reg};
    assign dy1n = {py_reg[COORD_BITS-1], py_reg} - {ey1_reg[COORD_BITS-1], ey1_reg};
    assign dy2p = {ey2_reg[COORD_BITS-1], ey2_reg} - {py_reg[COORD_BITS-1], py_reg};
    assign dy2n = {py_reg[COORD_BITS-1], py_reg} - {ey2_reg[COORD_BITS-1], ey2_reg};

    assign s1    = ex1_reg < px_reg;
    assign s2    = ex2_reg < px_reg;
    assign swap  = ey1_reg < ey2_reg;       // endpoint 1 becomes the upper one
    assign xl1   = swap ? s2 : s1;
    assign horiz = ey1_reg == ey2_reg;
    assign outy  = (ey1_reg > py_reg && ey2_reg > py_reg) ||
                   (ey1_reg < py_reg && ey2_reg < py_reg);
    assign dec   = horiz || outy || (s1 && s2) || (!s1 && !s2);
    assign dval  = !horiz && !outy && !s1 && !s2;

    assign ax   = swap ? dx2p : dx1p;
    assign nega = swap ? dx2n : dx1n;
    assign bx   = swap ? dx1p : dx2p;
    assign negb = swap ? dx1n : dx2n;
    assign uu   = swap ? dy2p : dy1p;
    assign vv   = swap ? dy1n : dy2n;

    logic [DIFF_W-1:0] pa_reg, pb_reg, qa_reg, qb_reg;
    logic              a_dec_reg, a_dval_reg;

    // crossing x >= px  <=>  pa*pb >= qa*qb, all operands non-negative
    always_ff @(posedge aclk) begin
        if (e_vld_reg) begin
            a_dec_reg  <= dec;
            a_dval_reg <= dval;
            pa_reg     <= xl1 ? bx   : ax;
            pb_reg     <= xl1 ? uu   : vv;
            qa_reg     <= xl1 ? nega : negb;
            qb_reg     <= xl1 ? vv   : uu;
        end
    end

    // stage B: products
    logic [PROD_W-1:0] p_reg, q_reg;
    logic              b_dec_reg, b_dval_reg;

    always_ff @(posedge aclk) begin
        if (a_vld_reg) begin
            p_reg      <= pa_reg * pb_reg;
            q_reg      <= qa_reg * qb_reg;
            b_dec_reg  <= a_dec_reg;
            b_dval_reg <= a_dval_reg;
        end
    end

    // stage C: parity of crossings
    logic par_reg, hit;

    assign hit = b_dec_reg ? b_dval_reg : (p_reg >= q_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            par_reg <= 1'b0;
        end else if (cmd.qchk) begin
            par_reg <= stat.in_box && !poly_reg;
        end else if (b_vld_reg && hit) begin
            par_reg <= !par_reg;
        end
    end

    // result word
    logic res_inside_reg, res_full_reg;

    always_ff @(posedge aclk) begin
        if (cmd.res_q) begin
            res_inside_reg <= par_reg;
            res_full_reg   <= 1'b0;
        end else if (do_item && act != ACT_QUERY) begin
            res_inside_reg <= 1'b0;
            res_full_reg   <= (act == ACT_ADD_VERTEX) && full;
        end
    end

    assign m_inside_res = res_inside_reg;
    assign m_table_full = res_full_reg;

endmodule

FILE: design/point_in_polygon_zone_test.sv
// Top level of the point-in-polygon zone test.
// Keeps a zone as a 3D box or as a polygon prism of up to MAX_VERTICES
// vertices and answers one result word per input word. Box resets, vertex
// adds and z range adds have their result word valid in the cycle after
// accept. Queries in box mode, or outside the bounding box, go from the box
// check straight to the result; a polygon query reads every stored vertex.
// The vertex memory is read one vertex per cycle. Each edge then passes a
// 4-stage crossing pipeline (edge forming, classify, multiply, compare)
// before the pipeline drains. A new word is taken once the previous one is
// done and the output register is free or being emptied. Configuration
// writes take effect at the write edge and are seen by the next box reset.
module point_in_polygon_zone_test
    import pip_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic signed [COORD_BITS-1:0] s_coord_x,
    input  logic signed [COORD_BITS-1:0] s_coord_y,
    input  logic signed [COORD_BITS-1:0] s_coord_z,
    input  logic signed [COORD_BITS-1:0] s_coord_z_second,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_inside_res,
    output logic                         m_table_full
);

    pip_cmd_t  cmd;
    pip_stat_t stat;

    pip_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pip_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_action         (s_action),
        .s_coord_x        (s_coord_x),
        .s_coord_y        (s_coord_y),
        .s_coord_z        (s_coord_z),
        .s_coord_z_second (s_coord_z_second),
        .cmd              (cmd),
        .stat             (stat),
        .m_inside_res     (m_inside_res),
        .m_table_full     (m_table_full)
    );

    // no new word while edges are still in flight
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !stat.busy)
        else $error("input ready while edge pipeline busy");

    // an accepted query is checked against the box on the next cycle
    a_query_chk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_action == ACT_QUERY) |=> cmd.qchk)
        else $error("query accepted without box check");

    a_vcount_max: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.vcount <= VCNT_W'(MAX_VERTICES))
        else $error("vertex count above table size");

    // a dropped vertex never reports inside
    a_res_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_inside_res && m_table_full))
        else $error("inside and table full both set");

endmodule
